// ===== sv/lfdb_pkg.sv =====
package lfdb_pkg;

    localparam int LEVEL_BITS  = 10;
    localparam int COUNT_BITS  = LEVEL_BITS + 1;
    localparam int SAMPLE_BITS = 10;
    localparam int MANUAL_BITS = 10;
    localparam int DUTY_BITS   = 8;
    localparam int MODE_BITS   = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 10;

    // Fixed-point coefficients: 232/256, 1021/4096, 46/1024
    localparam logic [7:0] FLASH_COEF   = 8'd232;
    localparam logic [5:0] FLASH_BASE   = 6'd49;
    localparam logic [9:0] DIM_COEF     = 10'd1021;
    localparam logic [5:0] BREATHE_COEF = 6'd46;
    localparam logic [3:0] BREATHE_BASE = 4'd15;

    localparam logic [DUTY_BITS-1:0]  DUTY_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_FLASH   = 2'd0,
        MODE_DIM     = 2'd1,
        MODE_BREATHE = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MODE    = 2'd0,
        CFG_USE_POT = 2'd1,
        CFG_MANUAL  = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [MODE_BITS-1:0]   mode;
        logic                   use_pot;
        logic [MANUAL_BITS-1:0] manual_level;
    } t_cfg;

endpackage

// ===== sv/lfdb_cfg.sv =====
module lfdb_cfg
    import lfdb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                     o_cfg_ready,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= MODE_FLASH;
            r_cfg.use_pot      <= 1'b1;
            r_cfg.manual_level <= '0;
        end else if (i_cfg_valid) begin
            // writes beyond the register list are dropped
            unique case (i_cfg_index)
                CFG_MODE:    r_cfg.mode         <= i_cfg_data[MODE_BITS-1:0];
                CFG_USE_POT: r_cfg.use_pot      <= i_cfg_data[0];
                CFG_MANUAL:  r_cfg.manual_level <= i_cfg_data[MANUAL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== sv/lfdb_engine.sv =====
module lfdb_engine
    import lfdb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  t_opcode                i_opcode,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  t_cfg                   i_cfg,
    output logic                   o_led_on,
    output logic [DUTY_BITS-1:0]   o_duty
);

    logic [LEVEL_BITS-1:0] r_level, n_level;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_led, n_led;
    logic [DUTY_BITS-1:0]  r_duty, n_duty;
    logic                  r_ramp_down, n_ramp_down;

    logic [LEVEL_BITS-1:0]   w_lv;
    logic [LEVEL_BITS+7:0]   w_flash_prod;
    logic [LEVEL_BITS+5:0]   w_breathe_prod;
    logic [LEVEL_BITS+9:0]   w_dim_prod;
    logic [LEVEL_BITS-3:0]   w_dim_raw;
    logic [DUTY_BITS-1:0]    w_dim_duty;
    logic [COUNT_BITS-1:0]   w_flash_lim;
    logic [COUNT_BITS-1:0]   w_breathe_lim;
    logic [COUNT_BITS-1:0]   w_count_inc;

    assign w_lv = i_cfg.use_pot ? r_level : LEVEL_BITS'(i_cfg.manual_level);

    assign w_flash_prod   = (LEVEL_BITS+8)'(w_lv) * (LEVEL_BITS+8)'(FLASH_COEF);
    assign w_breathe_prod = (LEVEL_BITS+6)'(w_lv) * (LEVEL_BITS+6)'(BREATHE_COEF);
    assign w_dim_prod     = (LEVEL_BITS+10)'(w_lv) * (LEVEL_BITS+10)'(DIM_COEF);

    assign w_flash_lim   = COUNT_BITS'(w_flash_prod[LEVEL_BITS+7:8])
                         + COUNT_BITS'(FLASH_BASE);
    assign w_breathe_lim = COUNT_BITS'(w_breathe_prod[LEVEL_BITS+5:10])
                         + COUNT_BITS'(BREATHE_BASE);

    assign w_dim_raw  = w_dim_prod[LEVEL_BITS+9:12];
    assign w_dim_duty = (LEVEL_BITS'(w_dim_raw) > LEVEL_BITS'(DUTY_MAX)) ?
                        DUTY_MAX : DUTY_BITS'(w_dim_raw);

    // counter saturates rather than wrapping
    assign w_count_inc = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

    always_comb begin
        n_level     = r_level;
        n_count     = r_count;
        n_led       = r_led;
        n_duty      = r_duty;
        n_ramp_down = r_ramp_down;
        if (i_fire) begin
            if (i_opcode == OP_SAMPLE) begin
                if (i_cfg.use_pot) begin
                    n_level = LEVEL_BITS'(i_sample);
                end
            end else begin
                n_count = w_count_inc;
                unique case (i_cfg.mode)
                    MODE_FLASH: begin
                        if (w_count_inc >= w_flash_lim) begin
                            n_led   = ~r_led;
                            n_count = '0;
                        end
                    end
                    MODE_DIM: begin
                        n_duty = w_dim_duty;
                    end
                    MODE_BREATHE: begin
                        if (w_count_inc >= w_breathe_lim) begin
                            n_count = '0;
                            if (!r_ramp_down) begin
                                if (r_duty != DUTY_MAX) begin
                                    n_duty = r_duty + 1'b1;
                                end
                            end else begin
                                if (r_duty != '0) begin
                                    n_duty = r_duty - 1'b1;
                                end
                            end
                            if (n_duty == DUTY_MAX) begin
                                n_ramp_down = 1'b1;
                            end
                            if (n_duty == '0) begin
                                n_ramp_down = 1'b0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_count     <= '0;
            r_led       <= 1'b0;
            r_duty      <= '0;
            r_ramp_down <= 1'b0;
        end else begin
            r_level     <= n_level;
            r_count     <= n_count;
            r_led       <= n_led;
            r_duty      <= n_duty;
            r_ramp_down <= n_ramp_down;
        end
    end

    assign o_led_on = n_led;
    assign o_duty   = n_duty;

    a_sample_keeps_outputs: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_opcode == OP_SAMPLE) |=> ($stable(r_led) && $stable(r_duty))
    ) else $error("sample item changed LED or duty");

    a_count_saturates: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_opcode == OP_TICK && i_cfg.mode == MODE_DIM
            && r_count == COUNT_MAX) |=> (r_count == COUNT_MAX)
    ) else $error("tick counter wrapped");

    a_toggle_clears_count: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_opcode == OP_TICK && i_cfg.mode == MODE_FLASH
            && n_led != r_led) |=> (r_count == '0)
    ) else $error("flash toggle left counter running");

endmodule

// ===== sv/led_flash_dim_breathe_engine_core.sv =====
// Path: an input transfer is captured in the input register, then passes
//   through the engine logic into the result register, which presents it.
// Throughput: one item per cycle unless the result is stalled; the result
//   and input registers let a new item in while a finished result is stalled.
// Reset (synchronous, active low): LED off, duty 0, counter 0, ramping up,
//   mode flash, converter source selected, manual level 0.
module led_flash_dim_breathe_engine_core
    import lfdb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_opcode,
    input  logic [SAMPLE_BITS-1:0]   i_sample,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_led_on,
    output logic [DUTY_BITS-1:0]     o_duty,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg w_cfg;

    logic                   r_in_valid;
    t_opcode                r_in_opcode;
    logic [SAMPLE_BITS-1:0] r_in_sample;
    logic                   r_out_valid;
    logic                   r_led_on;
    logic [DUTY_BITS-1:0]   r_duty;

    logic                   w_advance;
    logic                   w_fire;
    logic                   w_in_take;
    logic                   w_led_on;
    logic [DUTY_BITS-1:0]   w_duty;

    lfdb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    // result register free, or being drained this cycle
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_advance;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_take  = i_in_valid && !o_in_stall;

    lfdb_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_opcode (r_in_opcode),
        .i_sample (r_in_sample),
        .i_cfg    (w_cfg),
        .o_led_on (w_led_on),
        .o_duty   (w_duty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_opcode <= t_opcode'(i_opcode);
            r_in_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_led_on <= w_led_on;
            r_duty   <= w_duty;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_led_on    = r_led_on;
    assign o_duty      = r_duty;

    a_fire_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid
    ) else $error("processed item produced no result");

    a_held_item_kept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> (r_in_valid && $stable(r_in_sample)
            && $stable(r_in_opcode))
    ) else $error("pending item lost from input register");

endmodule

// ===== test/led_flash_dim_breathe_engine_core_test.sv =====
`timescale 1ns / 1ps

module led_flash_dim_breathe_engine_core_test;
    import lfdb_pkg::*;

    localparam int PIPE_LATENCY = 2;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        t_opcode                op;
        logic [SAMPLE_BITS-1:0] sample;
    } t_led_item;

    typedef struct packed {
        logic                 led_on;
        logic [DUTY_BITS-1:0] duty;
    } t_led_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic                     i_opcode = 1'b0;
    logic [SAMPLE_BITS-1:0]   i_sample = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_led_on;
    logic [DUTY_BITS-1:0]     o_duty;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    led_flash_dim_breathe_engine_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_led_on    (o_led_on),
        .o_duty      (o_duty),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // engine state and registers as the predictor sees them
    logic [MODE_BITS-1:0]   cfg_mode = MODE_FLASH;
    logic                   cfg_pot = 1'b1;
    logic [MANUAL_BITS-1:0] cfg_manual = '0;
    logic [LEVEL_BITS-1:0]  pot_level = '0;
    logic [COUNT_BITS-1:0]  tick_cnt = '0;
    logic                   led_state = 1'b0;
    logic [DUTY_BITS-1:0]   duty_state = '0;
    logic                   ramp_down = 1'b0;

    t_led_item   stim_q[$];
    t_led_result expected_q[$];
    int          n_pushed = 0;
    int          n_accepted = 0;
    int          errors = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct = 12;
    int          recv_idle_pct = 55;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    bit          in_taken = 1'b0;

    function automatic t_led_result engine_predict(input t_opcode op,
                                                   input logic [SAMPLE_BITS-1:0] smp);
        int unsigned lv;
        int unsigned thr;
        int unsigned dim;
        t_led_result res;
        if (op == OP_SAMPLE) begin
            if (cfg_pot)
                pot_level = smp[LEVEL_BITS-1:0];
        end else begin
            lv = cfg_pot ? 32'(pot_level) : 32'(cfg_manual);
            if (tick_cnt != COUNT_MAX)
                tick_cnt = tick_cnt + 1'b1;
            case (cfg_mode)
                MODE_FLASH: begin
                    thr = ((lv * 232) >> 8) + 49;
                    if (tick_cnt >= thr) begin
                        led_state = ~led_state;
                        tick_cnt = '0;
                    end
                end
                MODE_DIM: begin
                    dim = (lv * 1021) >> 12;
                    duty_state = (dim > 255) ? DUTY_MAX : dim[DUTY_BITS-1:0];
                end
                MODE_BREATHE: begin
                    thr = ((lv * 46) >> 10) + 15;
                    if (tick_cnt >= thr) begin
                        tick_cnt = '0;
                        if (!ramp_down) begin
                            if (duty_state != DUTY_MAX)
                                duty_state = duty_state + 1'b1;
                        end else begin
                            if (duty_state != '0)
                                duty_state = duty_state - 1'b1;
                        end
                        if (duty_state == DUTY_MAX)
                            ramp_down = 1'b1;
                        if (duty_state == '0)
                            ramp_down = 1'b0;
                    end
                end
                default: ;
            endcase
        end
        res.led_on = led_state;
        res.duty   = duty_state;
        return res;
    endfunction

    // sample transfers at the rising edge, check results, watchdog
    always @(posedge i_clk) begin
        t_led_result exp_res;
        bit          moved;
        moved = 1'b0;
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken) begin
            expected_q.push_back(engine_predict(t_opcode'(i_opcode), i_sample));
            n_accepted++;
            moved = 1'b1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            moved = 1'b1;
            if (expected_q.size() == 0) begin
                $error("result transfer with nothing pending: led_on %0d duty %0d",
                       o_led_on, o_duty);
                errors++;
            end else begin
                exp_res = expected_q.pop_front();
                if (o_led_on !== exp_res.led_on) begin
                    $error("led_on mismatch: expected %0d, got %0d", exp_res.led_on, o_led_on);
                    errors++;
                end
                if (o_duty !== exp_res.duty) begin
                    $error("duty mismatch: expected %0d, got %0d", exp_res.duty, o_duty);
                    errors++;
                end
            end
        end
        if (i_cfg_valid && o_cfg_ready)
            moved = 1'b1;
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // input driver
    always @(negedge i_clk) begin
        t_led_item item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (stim_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                item = stim_q.pop_front();
                i_in_valid <= 1'b1;
                i_opcode   <= item.op;
                i_sample   <= item.sample;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result-side stall, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic add_item(input t_opcode op, input logic [SAMPLE_BITS-1:0] smp);
        t_led_item item;
        item.op = op;
        item.sample = smp;
        stim_q.push_back(item);
        n_pushed++;
    endtask

    task automatic wait_idle();
        while (n_accepted != n_pushed || expected_q.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_LATENCY + 3) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MODE:    cfg_mode = data[MODE_BITS-1:0];
            CFG_USE_POT: cfg_pot = data[0];
            CFG_MANUAL:  cfg_manual = data[MANUAL_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_ticks(input int n);
        repeat (n) add_item(OP_TICK, SAMPLE_BITS'($urandom_range(1023)));
    endtask

    task automatic random_burst(input int n_items, input bit with_hold);
        int r;
        logic [MODE_BITS-1:0]   m;
        logic [MANUAL_BITS-1:0] man;
        wait_idle();
        r = $urandom_range(9);
        m = (r < 3) ? MODE_FLASH : (r < 6) ? MODE_DIM : (r < 9) ? MODE_BREATHE : MODE_UNUSED;
        r = $urandom_range(3);
        man = (r == 0) ? '0 : (r == 1) ? '1 :
              (r == 2) ? MANUAL_BITS'($urandom_range(127)) : MANUAL_BITS'($urandom_range(1023));
        cfg_write(CFG_MODE, CFG_DATA_BITS'(m));
        cfg_write(CFG_USE_POT, CFG_DATA_BITS'($urandom_range(1)));
        cfg_write(CFG_MANUAL, man);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < 15) begin
                if ($urandom_range(9) < 7)
                    add_item(OP_SAMPLE, SAMPLE_BITS'($urandom_range(63)));
                else
                    add_item(OP_SAMPLE, SAMPLE_BITS'($urandom_range(1023)));
            end else begin
                add_ticks(1);
            end
        end
        if (with_hold) begin
            @(posedge i_clk);
            hold_req = 1'b1;
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: flash, level extremes and alternating bit patterns
        cfg_write(CFG_MODE, CFG_DATA_BITS'(MODE_FLASH));
        cfg_write(CFG_USE_POT, CFG_DATA_BITS'(1));
        cfg_write(CFG_MANUAL, '0);
        add_item(OP_SAMPLE, '1);
        add_item(OP_SAMPLE, '0);
        add_item(OP_SAMPLE, 10'h2AA);
        add_item(OP_SAMPLE, 10'h155);
        add_ticks(2);

        // dim from the converter, full scale to zero
        wait_idle();
        cfg_write(CFG_MODE, CFG_DATA_BITS'(MODE_DIM));
        add_item(OP_SAMPLE, '1);
        add_ticks(1);
        add_item(OP_SAMPLE, '0);
        add_ticks(1);
        add_item(OP_SAMPLE, 10'd512);
        add_ticks(1);

        // manual source: samples must not move the level
        wait_idle();
        cfg_write(CFG_USE_POT, CFG_DATA_BITS'(0));
        cfg_write(CFG_MANUAL, '1);
        add_ticks(1);
        add_item(OP_SAMPLE, 10'd5);
        add_ticks(1);

        // breathe at the shortest period: one step after fifteen counts
        wait_idle();
        cfg_write(CFG_MODE, CFG_DATA_BITS'(MODE_BREATHE));
        cfg_write(CFG_USE_POT, CFG_DATA_BITS'(1));
        cfg_write(CFG_MANUAL, '0);
        add_item(OP_SAMPLE, '0);
        add_ticks(16);

        random_burst(140, 1'b0);
        random_burst(140, 1'b0);

        wait_idle();
        send_idle_pct = 55;
        recv_idle_pct = 12;
        random_burst(140, 1'b0);
        random_burst(140, 1'b0);

        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_burst(140, 1'b1);
        random_burst(140, 1'b0);

        wait_idle();
        send_idle_pct = 12;
        recv_idle_pct = 12;
        random_burst(130, 1'b0);

        wait_idle();
        repeat (4 * PIPE_LATENCY) @(negedge i_clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/lfdb_pkg.sv
sv/lfdb_cfg.sv
sv/lfdb_engine.sv
sv/led_flash_dim_breathe_engine_core.sv
test/led_flash_dim_breathe_engine_core_test.sv
